// ===== sv/led_ring_clock_fader_defines.svh =====
// assertion macros for the led ring clock fader
`ifndef LED_RING_CLOCK_FADER_DEFINES_SVH
`define LED_RING_CLOCK_FADER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define LRCF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define LRCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/lrcf_pkg.sv =====
`default_nettype none
package lrcf_pkg;
    localparam int SecondsPerMinuteDefault = 150;

    typedef enum logic [1:0] {
        OP_PWM    = 2'd0,
        OP_FADE   = 2'd1,
        OP_KEY    = 2'd2,
        OP_SECOND = 2'd3
    } opcode_t;

    localparam logic [1:0] MODE_LIVE = 2'd0;
    localparam logic [1:0] MODE_SET_HOURS = 2'd1;
    localparam logic [1:0] MODE_SET_MINUTES = 2'd2;

    localparam logic [2:0] REG_STEP_OVER_LOW = 3'd0;
    localparam logic [2:0] REG_STEP_OVER_HIGH = 3'd1;
    localparam logic [2:0] REG_DELAY_SLOW = 3'd2;
    localparam logic [2:0] REG_DELAY_MEDIUM = 3'd3;
    localparam logic [2:0] REG_DELAY_FAST = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS_STEP = 3'd5;
    localparam logic [2:0] REG_BRIGHTNESS_MAX = 3'd6;
    localparam logic [2:0] REG_BRIGHTNESS_MIN = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic       supply_good;
        logic       key_mode;
        logic       key_plus;
        logic       key_minus;
    } in_beat_t;

    typedef struct packed {
        logic [11:0] minute_leds;
        logic [11:0] hour_leds;
        logic [1:0]  mode_now;
        logic [4:0]  hour_now;
        logic [4:0]  hyperminute_now;
        logic [7:0]  brightness_now;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] data;
    } cfg_beat_t;
endpackage
`default_nettype wire

// ===== sv/lrcf_stream_if.sv =====
`default_nettype none
interface lrcf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/led_ring_clock_fader.sv =====
// channel | role   | payload
// in_ch   | sink   | opcode, supply_good, key_mode, key_plus, key_minus
// out_ch  | source | minute_leds, hour_leds, mode_now, hour_now, hyperminute_now,
//         |        |   brightness_now
// cfg_ch  | sink   | index (register number), data
// one beat per cycle: an event updates the state in the cycle it is taken and its
//   result goes to a one-entry output register, valid in the next cycle
// the input is ready whenever the output register is empty or being drained
// a stall on the output holds the result and blocks the input; no internal queue
// asynchronous active-low reset loads the power-up state with leds chosen
//   for hour 1, hyperminute 23
`default_nettype none
`include "led_ring_clock_fader_defines.svh"
module led_ring_clock_fader #(
    parameter int SECONDS_PER_MINUTE = lrcf_pkg::SecondsPerMinuteDefault
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lrcf_stream_if.sink   in_ch,
    lrcf_stream_if.source out_ch,
    lrcf_stream_if.sink   cfg_ch
);
    import lrcf_pkg::*;

    localparam logic [7:0] SpmLast = 8'(SECONDS_PER_MINUTE);

    // configuration registers
    logic [7:0] sol_reg, soh_reg, dslow_reg, dmed_reg, dfast_reg;
    logic [7:0] bstep_reg, bmax_reg, bmin_reg;

    // state
    logic [1:0]  mode_reg, mode_next;
    logic [7:0]  phase_reg, phase_next, top_reg, top_next;
    logic [7:0]  min_lvl_reg, min_lvl_next, mout_lvl_reg, mout_lvl_next;
    logic [7:0]  hr_lvl_reg, hr_lvl_next;
    logic [7:0]  min_tk_reg, min_tk_next, mout_tk_reg, mout_tk_next;
    logic [7:0]  hr_tk_reg, hr_tk_next;
    logic        hr_fade_reg, hr_fade_next, blink_reg, blink_next;
    logic        await_reg, await_next, asleep_reg, asleep_next;
    logic [3:0]  blink_tk_reg, blink_tk_next;
    logic [7:0]  sec_reg, sec_next;
    logic [4:0]  hm_reg, hm_next, hr_reg, hr_next;
    logic [3:0]  m_rise_reg, m_rise_next, m_stdy_reg, m_stdy_next;
    logic [3:0]  m_fall_reg, m_fall_next, h_rise_reg, h_rise_next;
    logic [3:0]  h_fall_reg, h_fall_next;
    logic [11:0] m_mask_reg, m_mask_next, h_mask_reg, h_mask_next;

    out_beat_t  out_reg;
    logic       out_valid_reg;
    logic       in_take;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_take = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    function automatic logic [11:0] led_put(logic [11:0] m, logic [3:0] led, logic on);
        logic [11:0] r;
        r = m;
        if (led >= 4'd1 && led <= 4'd12)
        begin
            r[led - 4'd1] = on;
        end
        return r;
    endfunction

    function automatic logic ramp_due(logic [7:0] lvl, logic [7:0] tk, logic [7:0] lo,
                                      logic [7:0] hi, logic [7:0] ds, logic [7:0] dm,
                                      logic [7:0] df);
        if (lvl <= lo)
        begin
            return tk >= ds;
        end
        if (lvl <= hi)
        begin
            return tk >= dm;
        end
        return tk >= df;
    endfunction

    always_comb
    begin
        in_beat_t   b;
        logic [4:0] hh;
        logic [4:0] m5;
        logic       do_hour, do_min;
        logic [8:0] sum;
        logic [7:0] tk;
        b = in_ch.data;
        mode_next = mode_reg; phase_next = phase_reg; top_next = top_reg;
        min_lvl_next = min_lvl_reg; mout_lvl_next = mout_lvl_reg; hr_lvl_next = hr_lvl_reg;
        min_tk_next = min_tk_reg; mout_tk_next = mout_tk_reg; hr_tk_next = hr_tk_reg;
        hr_fade_next = hr_fade_reg; blink_next = blink_reg; await_next = await_reg;
        asleep_next = asleep_reg; blink_tk_next = blink_tk_reg; sec_next = sec_reg;
        hm_next = hm_reg; hr_next = hr_reg; m_rise_next = m_rise_reg;
        m_stdy_next = m_stdy_reg; m_fall_next = m_fall_reg; h_rise_next = h_rise_reg;
        h_fall_next = h_fall_reg; m_mask_next = m_mask_reg; h_mask_next = h_mask_reg;
        do_hour = 1'b0;
        do_min = 1'b0;
        sum = '0;
        tk = '0;
        hh = '0;
        m5 = '0;

        // clock advance shared by live second ticks, awake or asleep
        if (b.opcode == OP_SECOND && mode_reg == MODE_LIVE)
        begin
            if (sec_reg == SpmLast)
            begin
                sec_next = 8'd1;
                if (hm_reg == 5'd24)
                begin
                    hm_next = 5'd1;
                    hr_next = (hr_reg == 5'd24) ? 5'd1 : hr_reg + 5'd1;
                    do_hour = b.supply_good;
                end
                else
                begin
                    hm_next = hm_reg + 5'd1;
                end
                do_min = b.supply_good;
            end
            else
            begin
                sec_next = sec_reg + 8'd1;
            end
        end

        if (asleep_reg)
        begin
            if (b.opcode == OP_SECOND)
            begin
                if (b.supply_good)
                begin
                    asleep_next = 1'b0;
                    do_hour = 1'b1;
                    do_min = 1'b1;
                end
                else
                begin
                    m_mask_next = '0;
                    h_mask_next = '0;
                end
            end
        end
        else
        begin
            case (b.opcode)
                OP_PWM:
                begin
                    if (!b.supply_good)
                    begin
                        m_mask_next = '0;
                        h_mask_next = '0;
                        asleep_next = 1'b1;
                    end
                    else if (mode_reg == MODE_LIVE)
                    begin
                        phase_next = phase_reg + 8'd1;
                        if (phase_next == 8'd0)
                        begin
                            if (min_lvl_reg != 8'd0)
                                m_mask_next = led_put(m_mask_next, m_rise_reg, 1'b1);
                            if (mout_lvl_reg != 8'd0)
                                m_mask_next = led_put(m_mask_next, m_fall_reg, 1'b1);
                            m_mask_next = led_put(m_mask_next, m_stdy_reg, 1'b1);
                            if (hr_lvl_reg != 8'd0)
                                h_mask_next = led_put(h_mask_next, h_rise_reg, 1'b1);
                            if (hr_lvl_reg < top_reg)
                                h_mask_next = led_put(h_mask_next, h_fall_reg, 1'b1);
                        end
                        if (phase_next == min_lvl_reg)
                            m_mask_next = led_put(m_mask_next, m_rise_reg, 1'b0);
                        if (phase_next == mout_lvl_reg)
                            m_mask_next = led_put(m_mask_next, m_fall_reg, 1'b0);
                        if (phase_next == top_reg)
                            m_mask_next = led_put(m_mask_next, m_stdy_reg, 1'b0);
                        if (phase_next == hr_lvl_reg)
                            h_mask_next = led_put(h_mask_next, h_rise_reg, 1'b0);
                        if (hr_lvl_reg <= top_reg && phase_next == top_reg - hr_lvl_reg)
                            h_mask_next = led_put(h_mask_next, h_fall_reg, 1'b0);
                    end
                    else if (mode_reg == MODE_SET_HOURS)
                    begin
                        h_mask_next = led_put(h_mask_reg, h_rise_reg, blink_reg);
                    end
                    else if (mode_reg == MODE_SET_MINUTES)
                    begin
                        m_mask_next = led_put(m_mask_reg, m_rise_reg, blink_reg);
                        m_mask_next = led_put(m_mask_next, m_stdy_reg, blink_reg);
                    end
                end
                OP_FADE:
                begin
                    if (mode_reg != MODE_LIVE)
                    begin
                        if (blink_tk_reg >= 4'd11)
                        begin
                            blink_tk_next = 4'd0;
                            blink_next = !blink_reg;
                        end
                        else
                        begin
                            blink_tk_next = blink_tk_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        tk = min_tk_reg + 8'd1;
                        min_tk_next = tk;
                        if (min_lvl_reg >= top_reg)
                            min_tk_next = 8'd0;
                        else if (ramp_due(min_lvl_reg, tk, sol_reg, soh_reg, dslow_reg,
                                          dmed_reg, dfast_reg))
                        begin
                            min_lvl_next = min_lvl_reg + 8'd1;
                            min_tk_next = 8'd0;
                        end
                        tk = mout_tk_reg + 8'd1;
                        mout_tk_next = tk;
                        if (mout_lvl_reg == 8'd0)
                            mout_tk_next = 8'd0;
                        else if (ramp_due(mout_lvl_reg, tk, sol_reg, soh_reg, dslow_reg,
                                          dmed_reg, dfast_reg))
                        begin
                            mout_lvl_next = mout_lvl_reg - 8'd1;
                            mout_tk_next = 8'd0;
                        end
                        if (hr_fade_reg)
                        begin
                            if (hr_lvl_reg == top_reg)
                            begin
                                hr_fade_next = 1'b0;
                                hr_tk_next = 8'd0;
                            end
                            else
                            begin
                                tk = hr_tk_reg + 8'd1;
                                hr_tk_next = tk;
                                if (ramp_due(hr_lvl_reg, tk, sol_reg, soh_reg, dslow_reg,
                                             dmed_reg, dfast_reg))
                                begin
                                    hr_lvl_next = hr_lvl_reg + 8'd1;
                                    hr_tk_next = 8'd0;
                                end
                            end
                        end
                    end
                end
                OP_KEY:
                begin
                    // at most one key is taken per sample, mode before plus before minus
                    if (!await_reg && (b.key_mode || b.key_plus || b.key_minus))
                    begin
                        await_next = 1'b1;
                        if (b.key_mode)
                        begin
                            mode_next = (mode_reg == MODE_LIVE) ? MODE_SET_HOURS :
                                        (mode_reg == MODE_SET_HOURS) ? MODE_SET_MINUTES :
                                        MODE_LIVE;
                            do_hour = 1'b1;
                            do_min = 1'b1;
                        end
                        else if (mode_reg == MODE_SET_HOURS)
                        begin
                            h_mask_next = led_put(h_mask_reg, h_rise_reg, 1'b0);
                            h_mask_next = led_put(h_mask_next, h_fall_reg, 1'b0);
                            if (b.key_plus)
                                hr_next = (hr_reg == 5'd24) ? 5'd1 : hr_reg + 5'd1;
                            else
                                hr_next = (hr_reg <= 5'd1) ? 5'd24 : hr_reg - 5'd1;
                            do_hour = 1'b1;
                        end
                        else if (mode_reg == MODE_SET_MINUTES)
                        begin
                            m_mask_next = led_put(m_mask_reg, m_rise_reg, 1'b0);
                            m_mask_next = led_put(m_mask_next, m_stdy_reg, 1'b0);
                            m_mask_next = led_put(m_mask_next, m_fall_reg, 1'b0);
                            if (b.key_plus)
                                hm_next = (hm_reg == 5'd24) ? 5'd1 : hm_reg + 5'd1;
                            else
                                hm_next = (hm_reg <= 5'd1) ? 5'd24 : hm_reg - 5'd1;
                            do_min = 1'b1;
                        end
                        else if (mode_reg == MODE_LIVE)
                        begin
                            if (b.key_plus)
                            begin
                                sum = {1'b0, top_reg} + {1'b0, bstep_reg};
                                if (sum < {1'b0, bmax_reg})
                                    top_next = sum[7:0];
                            end
                            else
                            begin
                                sum = {1'b0, bstep_reg} + {1'b0, bmin_reg};
                                if ({1'b0, top_reg} > sum)
                                    top_next = top_reg - bstep_reg;
                            end
                            min_lvl_next = top_next;
                            mout_lvl_next = 8'd0;
                            hr_lvl_next = top_next;
                        end
                    end
                    if (!b.key_mode && !b.key_plus && !b.key_minus)
                        await_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // led choice from the updated counts
        if (do_hour)
        begin
            hh = (hr_next > 5'd12) ? hr_next - 5'd12 : hr_next;
            h_rise_next = hh[3:0];
            h_fall_next = (hh[3:0] == 4'd1) ? 4'd12 : hh[3:0] - 4'd1;
            hr_lvl_next = 8'd0;
            hr_fade_next = 1'b1;
            // adjusting hours leaves no fade-out led
            if (b.opcode == OP_KEY && !b.key_mode)
                h_fall_next = 4'd0;
        end
        if (do_min)
        begin
            m5 = hm_next;
            if (m5[0])
            begin
                m_rise_next = 4'd0;
                if (m5 == 5'd1)
                begin
                    m_stdy_next = 4'd1;
                    m_fall_next = 4'd12;
                end
                else
                begin
                    hh = (m5 + 5'd1) >> 1;
                    m_stdy_next = hh[3:0];
                    m_fall_next = hh[3:0] - 4'd1;
                end
                mout_lvl_next = top_next;
            end
            else
            begin
                if (m5 == 5'd24)
                begin
                    m_rise_next = 4'd1;
                    m_stdy_next = 4'd12;
                end
                else
                begin
                    hh = (m5 + 5'd2) >> 1;
                    m_rise_next = hh[3:0];
                    m_stdy_next = hh[3:0] - 4'd1;
                end
                min_lvl_next = 8'd0;
                m_fall_next = 4'd0;
            end
        end
    end

    // indexes past the register list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sol_reg <= 8'd64; soh_reg <= 8'd160; dslow_reg <= 8'd8;
            dmed_reg <= 8'd4; dfast_reg <= 8'd2; bstep_reg <= 8'd16;
            bmax_reg <= 8'd255; bmin_reg <= 8'd16;
        end
        else if (cfg_ch.valid && cfg_ch.ready && cfg_ch.data.index[7:3] == 5'd0)
        begin
            unique case (cfg_ch.data.index[2:0])
                REG_STEP_OVER_LOW:   sol_reg <= cfg_ch.data.data;
                REG_STEP_OVER_HIGH:  soh_reg <= cfg_ch.data.data;
                REG_DELAY_SLOW:      dslow_reg <= cfg_ch.data.data;
                REG_DELAY_MEDIUM:    dmed_reg <= cfg_ch.data.data;
                REG_DELAY_FAST:      dfast_reg <= cfg_ch.data.data;
                REG_BRIGHTNESS_STEP: bstep_reg <= cfg_ch.data.data;
                REG_BRIGHTNESS_MAX:  bmax_reg <= cfg_ch.data.data;
                REG_BRIGHTNESS_MIN:  bmin_reg <= cfg_ch.data.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LIVE; phase_reg <= '0; top_reg <= 8'd128;
            min_lvl_reg <= '0; mout_lvl_reg <= 8'd128; hr_lvl_reg <= '0;
            min_tk_reg <= '0; mout_tk_reg <= '0; hr_tk_reg <= '0;
            hr_fade_reg <= 1'b1; blink_reg <= 1'b0; await_reg <= 1'b0;
            asleep_reg <= 1'b0; blink_tk_reg <= '0; sec_reg <= 8'd1;
            hm_reg <= 5'd23; hr_reg <= 5'd1; m_rise_reg <= 4'd0;
            m_stdy_reg <= 4'd12; m_fall_reg <= 4'd11; h_rise_reg <= 4'd1;
            h_fall_reg <= 4'd12; m_mask_reg <= '0; h_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                mode_reg <= mode_next; phase_reg <= phase_next; top_reg <= top_next;
                min_lvl_reg <= min_lvl_next; mout_lvl_reg <= mout_lvl_next;
                hr_lvl_reg <= hr_lvl_next; min_tk_reg <= min_tk_next;
                mout_tk_reg <= mout_tk_next; hr_tk_reg <= hr_tk_next;
                hr_fade_reg <= hr_fade_next; blink_reg <= blink_next;
                await_reg <= await_next; asleep_reg <= asleep_next;
                blink_tk_reg <= blink_tk_next; sec_reg <= sec_next; hm_reg <= hm_next;
                hr_reg <= hr_next; m_rise_reg <= m_rise_next; m_stdy_reg <= m_stdy_next;
                m_fall_reg <= m_fall_next; h_rise_reg <= h_rise_next;
                h_fall_reg <= h_fall_next; m_mask_reg <= m_mask_next;
                h_mask_reg <= h_mask_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload follows the state just taken
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            out_reg.minute_leds <= m_mask_next;
            out_reg.hour_leds <= h_mask_next;
            out_reg.mode_now <= mode_next;
            out_reg.hour_now <= hr_next;
            out_reg.hyperminute_now <= hm_next;
            out_reg.brightness_now <= top_next;
        end
    end

    `LRCF_ASSERT_NEXT(a_take_gives_result, in_take, out_valid_reg)
    `LRCF_ASSERT_IMP(a_mode_legal, 1'b1, mode_reg <= MODE_SET_MINUTES)
    `LRCF_ASSERT_IMP(a_sleep_dark, asleep_reg, m_mask_reg == '0 && h_mask_reg == '0)
    `LRCF_ASSERT_IMP(a_hour_range, 1'b1, hr_reg >= 5'd1 && hr_reg <= 5'd24)
endmodule
`default_nettype wire
